// ===== rtl/core/acf_pkg.sv =====
// shared types and constants for the address-claim controller
`default_nettype none

package acf_pkg;

    // addresses and group number
    localparam logic [7:0]  NULL_ADDR     = 8'd254;
    localparam logic [15:0] CLAIM_PGN     = 16'hEE00;
    localparam logic [3:0]  MIN_FRAME_LEN = 4'd8;

    // claim phase codes
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_CLAIMING   = 3'd1;
    localparam logic [2:0] PH_CLAIMED    = 3'd2;
    localparam logic [2:0] PH_CONTENTION = 3'd3;
    localparam logic [2:0] PH_CANNOT     = 3'd4;

    // event kinds
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_FRAME = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_OWN_NAME     = 3'd0;
    localparam logic [2:0] REG_PREFERRED    = 3'd1;
    localparam logic [2:0] REG_PRIORITY     = 3'd2;
    localparam logic [2:0] REG_ARBITRARY    = 3'd3;
    localparam logic [2:0] REG_TIMEOUT      = 3'd4;
    localparam logic [2:0] REG_LOW_UNICAST  = 3'd5;
    localparam logic [2:0] REG_HIGH_UNICAST = 3'd6;

    // configuration reset values
    localparam logic [63:0] RST_OWN_NAME     = 64'd0;
    localparam logic [7:0]  RST_PREFERRED    = 8'd128;
    localparam logic [2:0]  RST_PRIORITY     = 3'd6;
    localparam logic        RST_ARBITRARY    = 1'b0;
    localparam logic [15:0] RST_TIMEOUT      = 16'd250;
    localparam logic [7:0]  RST_LOW_UNICAST  = 8'd0;
    localparam logic [7:0]  RST_HIGH_UNICAST = 8'd253;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration register file contents
    typedef struct packed {
        logic [63:0] own_name;
        logic [7:0]  start_addr;
        logic [2:0]  frame_priority;
        logic        may_search;
        logic [15:0] claim_timeout_ticks;
        logic [7:0]  lowest_unicast;
        logic [7:0]  highest_unicast;
    } cfg_t;

    // classified event handed from front to back
    typedef struct packed {
        logic [1:0] opcode;
        logic       frame_ok;
        logic [7:0] frame_addr;
        logic       name_lt;
        logic       name_eq;
    } cmd_t;

    // queue status seen by the front
    typedef struct packed {
        logic full;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/acf_evt_if.sv =====
// event request channel
`default_nettype none

interface acf_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [28:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_data;

    modport source (output valid, opcode, frame_id, frame_length, frame_data, input ready);
    modport sink   (input valid, opcode, frame_id, frame_length, frame_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/acf_res_if.sv =====
// result request channel
`default_nettype none

interface acf_res_if;
    logic        valid;
    logic        ready;
    logic        send_valid;
    logic [28:0] send_id;
    logic [63:0] send_data;
    logic        notify_valid;
    logic [7:0]  notify_address;
    logic [2:0]  notify_state;
    logic [7:0]  addr_now;
    logic [2:0]  claim_phase;

    modport source (output valid, send_valid, send_id, send_data, notify_valid,
                    notify_address, notify_state, addr_now, claim_phase,
                    input ready);
    modport sink   (input valid, send_valid, send_id, send_data, notify_valid,
                    notify_address, notify_state, addr_now, claim_phase,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/acf_cfg_if.sv =====
// configuration write channel
`default_nettype none

interface acf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/can_address_claim_fsm_core.sv =====
// top level of the CAN address-claim controller
//
// Channels: evt takes one event (start, stop, received frame, tick) per
// request; res returns exactly one result per event, in order; cfg writes
// the seven configuration registers by index (indexes past the list are
// dropped). All channels complete when valid and ready are both high.
// Configuration is meant to be written while no event is in flight.
// Path: an event is written into the queue when it is accepted, and its
// result into the result register when the back pops it.
// Throughput: one event per cycle while res takes results; the front
// decodes the frame filter and the 64-bit NAME compare, a queue of
// QUEUE_DEPTH entries hands the decoded event to the back, which
// updates the claim state and the result register together.
// When res stalls, the result register holds and the queue absorbs up to
// QUEUE_DEPTH further events before evt.ready drops.
// Reset: address 254 (none), phase idle, timer disarmed, registers at
// their defaults; no result is pending.
`default_nettype none

module can_address_claim_fsm_core #(
    parameter int QUEUE_DEPTH = acf_pkg::QUEUE_DEPTH
) (
    input  wire       clk,
    input  wire       rst_n,
    acf_evt_if.sink   evt,
    acf_res_if.source res,
    acf_cfg_if.sink   cfg
);

    acf_pkg::queue_status_t q_status;
    acf_pkg::cmd_t          push_cmd;
    acf_pkg::cmd_t          head_cmd;
    acf_pkg::cfg_t          cfg_regs;
    logic                   push;
    logic                   pop;
    logic                   head_valid;

    // decode and configuration
    acf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt      (evt),
        .cfg      (cfg),
        .q_status (q_status),
        .push     (push),
        .cmd      (push_cmd),
        .cfg_regs (cfg_regs)
    );

    // decoupling queue
    acf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .status     (q_status)
    );

    // claim state and result
    acf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_regs   (cfg_regs),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .res        (res)
    );

endmodule

`default_nettype wire

// ===== rtl/core/acf_front.sv =====
// front end: configuration registers and event classification
`default_nettype none

module acf_front (
    input  wire                    clk,
    input  wire                    rst_n,
    acf_evt_if.sink                evt,
    acf_cfg_if.sink                cfg,
    input  acf_pkg::queue_status_t q_status,
    output logic                   push,
    output acf_pkg::cmd_t          cmd,
    output acf_pkg::cfg_t          cfg_regs
);

    acf_pkg::cfg_t cfg_reg;

    // configuration writes are always taken
    assign cfg.ready = 1'b1;

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_name            <= acf_pkg::RST_OWN_NAME;
            cfg_reg.start_addr          <= acf_pkg::RST_PREFERRED;
            cfg_reg.frame_priority      <= acf_pkg::RST_PRIORITY;
            cfg_reg.may_search          <= acf_pkg::RST_ARBITRARY;
            cfg_reg.claim_timeout_ticks <= acf_pkg::RST_TIMEOUT;
            cfg_reg.lowest_unicast      <= acf_pkg::RST_LOW_UNICAST;
            cfg_reg.highest_unicast     <= acf_pkg::RST_HIGH_UNICAST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                acf_pkg::REG_OWN_NAME:     cfg_reg.own_name <= cfg.data;
                acf_pkg::REG_PREFERRED:    cfg_reg.start_addr <= cfg.data[7:0];
                acf_pkg::REG_PRIORITY:     cfg_reg.frame_priority <= cfg.data[2:0];
                acf_pkg::REG_ARBITRARY:    cfg_reg.may_search <= cfg.data[0];
                acf_pkg::REG_TIMEOUT:      cfg_reg.claim_timeout_ticks <= cfg.data[15:0];
                acf_pkg::REG_LOW_UNICAST:  cfg_reg.lowest_unicast <= cfg.data[7:0];
                acf_pkg::REG_HIGH_UNICAST: cfg_reg.highest_unicast <= cfg.data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg_regs = cfg_reg;

    // take an event whenever the queue has room
    assign evt.ready = !q_status.full;
    assign push      = evt.valid && !q_status.full;

    // state-independent part of the decode: frame filter and name compare
    always_comb
    begin
        cmd.opcode     = evt.opcode;
        cmd.frame_ok   = (evt.frame_length >= acf_pkg::MIN_FRAME_LEN)
                         && (evt.frame_id[23:8] == acf_pkg::CLAIM_PGN);
        cmd.frame_addr = evt.frame_id[7:0];
        cmd.name_lt    = cfg_reg.own_name < evt.frame_data;
        cmd.name_eq    = cfg_reg.own_name == evt.frame_data;
    end

endmodule

`default_nettype wire

// ===== rtl/core/acf_queue.sv =====
// short queue of classified events between front and back
`default_nettype none

module acf_queue #(
    parameter int DEPTH = acf_pkg::QUEUE_DEPTH
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  acf_pkg::cmd_t          push_cmd,
    input  wire                    pop,
    output logic                   head_valid,
    output acf_pkg::cmd_t          head_cmd,
    output acf_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    acf_pkg::cmd_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign do_push = push && (count_reg != CNT_W'(DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_valid  = count_reg != '0;
    assign head_cmd    = slot_reg[rd_ptr_reg];
    assign status.full = count_reg == CNT_W'(DEPTH);

endmodule

`default_nettype wire

// ===== rtl/core/acf_back.sv =====
// back end: claim state, tick timer and registered result
`default_nettype none

module acf_back (
    input  wire           clk,
    input  wire           rst_n,
    input  acf_pkg::cfg_t cfg_regs,
    input  wire           head_valid,
    input  acf_pkg::cmd_t head_cmd,
    output logic          pop,
    acf_res_if.source     res
);

    logic [7:0]  held_reg;
    logic [7:0]  held_next;
    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [15:0] timer_reg;
    logic [15:0] timer_next;
    logic        armed_reg;
    logic        armed_next;

    logic        out_valid_reg;
    logic        send_valid_reg;
    logic        send_valid_next;
    logic [7:0]  send_addr_reg;
    logic [7:0]  send_addr_next;
    logic [63:0] send_data_reg;
    logic        notify_valid_reg;
    logic        notify_valid_next;
    logic [7:0]  notify_addr_reg;
    logic [7:0]  notify_addr_next;
    logic [2:0]  notify_state_reg;
    logic [2:0]  notify_state_next;
    logic [2:0]  send_prio_reg;

    logic        load;
    logic        frame_hit;
    logic        give_up;
    logic [7:0]  nxt_addr;
    logic [7:0]  pick_addr;

    // result register frees up when empty or taken
    assign load = !out_valid_reg || res.ready;
    assign pop  = head_valid && load;

    // next address in the allowed range after the held one
    assign nxt_addr  = held_reg + 8'd1;
    assign pick_addr = (nxt_addr >= cfg_regs.lowest_unicast
                        && nxt_addr <= cfg_regs.highest_unicast)
                       ? nxt_addr : cfg_regs.lowest_unicast;

    assign frame_hit = head_cmd.frame_ok && (head_cmd.frame_addr == held_reg)
                       && (phase_reg == acf_pkg::PH_CLAIMING);

    // losing without a usable alternative
    assign give_up = head_cmd.name_eq || !cfg_regs.may_search
                     || (cfg_regs.lowest_unicast > cfg_regs.highest_unicast)
                     || ((cfg_regs.lowest_unicast == cfg_regs.highest_unicast)
                         && (cfg_regs.lowest_unicast == held_reg));

    // event execution
    always_comb
    begin
        held_next         = held_reg;
        phase_next        = phase_reg;
        timer_next        = timer_reg;
        armed_next        = armed_reg;
        send_valid_next   = 1'b0;
        send_addr_next    = held_reg;
        notify_valid_next = 1'b0;
        notify_addr_next  = acf_pkg::NULL_ADDR;
        notify_state_next = acf_pkg::PH_IDLE;
        case (head_cmd.opcode)
            acf_pkg::OP_START:
            begin
                if (phase_reg != acf_pkg::PH_CLAIMED)
                begin
                    held_next       = cfg_regs.start_addr;
                    phase_next      = acf_pkg::PH_CLAIMING;
                    send_valid_next = 1'b1;
                    send_addr_next  = cfg_regs.start_addr;
                    armed_next      = 1'b1;
                    timer_next      = cfg_regs.claim_timeout_ticks;
                end
            end
            acf_pkg::OP_STOP:
            begin
                armed_next      = 1'b0;
                timer_next      = '0;
                send_valid_next = held_reg != acf_pkg::NULL_ADDR;
                send_addr_next  = acf_pkg::NULL_ADDR;
                held_next       = acf_pkg::NULL_ADDR;
                phase_next      = acf_pkg::PH_IDLE;
            end
            acf_pkg::OP_FRAME:
            begin
                if (frame_hit)
                begin
                    if (head_cmd.name_lt)
                    begin
                        phase_next        = acf_pkg::PH_CLAIMED;
                        armed_next        = 1'b0;
                        timer_next        = '0;
                        notify_valid_next = 1'b1;
                        notify_addr_next  = held_reg;
                        notify_state_next = acf_pkg::PH_CLAIMED;
                    end
                    else if (give_up)
                    begin
                        phase_next        = acf_pkg::PH_CANNOT;
                        held_next         = acf_pkg::NULL_ADDR;
                        armed_next        = 1'b0;
                        timer_next        = '0;
                        notify_valid_next = 1'b1;
                        notify_addr_next  = acf_pkg::NULL_ADDR;
                        notify_state_next = acf_pkg::PH_CANNOT;
                    end
                    else
                    begin
                        held_next       = pick_addr;
                        phase_next      = acf_pkg::PH_CLAIMING;
                        send_valid_next = 1'b1;
                        send_addr_next  = pick_addr;
                        armed_next      = 1'b1;
                        timer_next      = cfg_regs.claim_timeout_ticks;
                    end
                end
            end
            acf_pkg::OP_TICK:
            begin
                if (armed_reg)
                begin
                    if (timer_reg > 16'd1)
                    begin
                        timer_next = timer_reg - 16'd1;
                    end
                    else
                    begin
                        armed_next = 1'b0;
                        timer_next = '0;
                        if (phase_reg == acf_pkg::PH_CLAIMING)
                        begin
                            phase_next        = acf_pkg::PH_CLAIMED;
                            notify_valid_next = 1'b1;
                            notify_addr_next  = held_reg;
                            notify_state_next = acf_pkg::PH_CLAIMED;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= acf_pkg::NULL_ADDR;
            phase_reg     <= acf_pkg::PH_IDLE;
            timer_reg     <= '0;
            armed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                held_reg  <= held_next;
                phase_reg <= phase_next;
                timer_reg <= timer_next;
                armed_reg <= armed_next;
            end
            if (load)
            begin
                out_valid_reg <= head_valid;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            send_valid_reg   <= send_valid_next;
            send_addr_reg    <= send_addr_next;
            send_prio_reg    <= cfg_regs.frame_priority;
            send_data_reg    <= send_valid_next ? cfg_regs.own_name : 64'd0;
            notify_valid_reg <= notify_valid_next;
            notify_addr_reg  <= notify_addr_next;
            notify_state_reg <= notify_state_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.send_valid     = send_valid_reg;
    assign res.send_id        = send_valid_reg
                                ? {send_prio_reg, 2'b00, acf_pkg::CLAIM_PGN, send_addr_reg}
                                : 29'd0;
    assign res.send_data      = send_data_reg;
    assign res.notify_valid   = notify_valid_reg;
    assign res.notify_address = notify_addr_reg;
    assign res.notify_state   = notify_state_reg;
    assign res.addr_now       = held_reg;
    assign res.claim_phase    = phase_reg;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// testbench for the address-claim controller: directed table, then random events checked by a predictor
module testbench;
    import acf_pkg::*;

    // one event request as driven on the event channel
    typedef struct packed {
        logic [1:0]  opcode;
        logic [28:0] frame_id;
        logic [3:0]  frame_length;
        logic [63:0] frame_data;
    } claim_event_t;

    // one result request as seen on the result channel
    typedef struct packed {
        logic        send_valid;
        logic [28:0] send_id;
        logic [63:0] send_data;
        logic        notify_valid;
        logic [7:0]  notify_address;
        logic [2:0]  notify_state;
        logic [7:0]  addr_now;
        logic [2:0]  claim_phase;
    } claim_result_t;

    // one line of the directed table: a register write or an event
    typedef struct {
        bit            is_write;
        logic [2:0]    index;
        logic [63:0]   value;
        claim_event_t  ev;
        bit            typed;
        claim_result_t want;
    } stim_row_t;

    localparam logic [2:0] REG_UNUSED     = 3'd7;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SEGMENT_ITEMS  = 121;

    logic clk;
    logic rst_n;

    acf_evt_if evt_ch ();
    acf_res_if res_ch ();
    acf_cfg_if cfg_ch ();

    can_address_claim_fsm_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // predictor state and its copy of the registers
    cfg_t        settings_q;
    logic [7:0]  held_addr_q;
    logic [2:0]  phase_q;
    logic [15:0] timer_left_q;
    logic        timer_on_q;

    claim_result_t pending_results[$];
    stim_row_t     directed_rows[$];

    int send_idle_pct = 26;
    int recv_idle_pct = 52;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // claim identifier with the configured priority
    function automatic logic [28:0] claim_frame_id(logic [7:0] addr);
        return {settings_q.frame_priority, 2'b00, CLAIM_PGN, addr};
    endfunction

    function automatic claim_result_t mk_result(logic sv, logic [28:0] sid, logic [63:0] sdata,
                                                logic nv, logic [7:0] na, logic [2:0] ns,
                                                logic [7:0] ca, logic [2:0] cp);
        claim_result_t r;
        r.send_valid     = sv;
        r.send_id        = sid;
        r.send_data      = sdata;
        r.notify_valid   = nv;
        r.notify_address = na;
        r.notify_state   = ns;
        r.addr_now       = ca;
        r.claim_phase    = cp;
        return r;
    endfunction

    // next claim state and the result one event causes
    function automatic claim_result_t predict_claim(claim_event_t ev);
        claim_result_t r;
        logic [7:0]    lo;
        logic [7:0]    hi;
        logic [7:0]    nxt;
        logic          lost;
        r = '0;
        r.notify_address = NULL_ADDR;
        r.notify_state = PH_IDLE;
        lost = 1'b0;
        lo = settings_q.lowest_unicast;
        hi = settings_q.highest_unicast;
        case (ev.opcode)
            OP_START:
            begin
                if (phase_q != PH_CLAIMED)
                begin
                    held_addr_q = settings_q.start_addr;
                    phase_q = PH_CLAIMING;
                    r.send_valid = 1'b1;
                    r.send_id = claim_frame_id(held_addr_q);
                    timer_on_q = 1'b1;
                    timer_left_q = settings_q.claim_timeout_ticks;
                end
            end
            OP_STOP:
            begin
                timer_on_q = 1'b0;
                timer_left_q = '0;
                if (held_addr_q != NULL_ADDR)
                begin
                    r.send_valid = 1'b1;
                    r.send_id = claim_frame_id(NULL_ADDR);
                end
                held_addr_q = NULL_ADDR;
                phase_q = PH_IDLE;
            end
            OP_FRAME:
            begin
                if (ev.frame_length >= MIN_FRAME_LEN && ev.frame_id[23:8] == CLAIM_PGN &&
                    ev.frame_id[7:0] == held_addr_q && phase_q == PH_CLAIMING)
                begin
                    if (settings_q.own_name < ev.frame_data)
                    begin
                        // our name wins, address kept
                        phase_q = PH_CLAIMED;
                        timer_on_q = 1'b0;
                        timer_left_q = '0;
                        r.notify_valid = 1'b1;
                        r.notify_address = held_addr_q;
                        r.notify_state = PH_CLAIMED;
                    end
                    else if (settings_q.own_name == ev.frame_data ||
                             !settings_q.may_search || lo > hi ||
                             (lo == hi && lo == held_addr_q))
                    begin
                        lost = 1'b1;
                    end
                    else
                    begin
                        // move on to the next address in range
                        nxt = held_addr_q + 8'd1;
                        held_addr_q = (nxt >= lo && nxt <= hi) ? nxt : lo;
                        r.send_valid = 1'b1;
                        r.send_id = claim_frame_id(held_addr_q);
                        timer_on_q = 1'b1;
                        timer_left_q = settings_q.claim_timeout_ticks;
                    end
                end
            end
            OP_TICK:
            begin
                if (timer_on_q)
                begin
                    if (timer_left_q > 16'd1)
                        timer_left_q = timer_left_q - 16'd1;
                    else
                    begin
                        timer_on_q = 1'b0;
                        timer_left_q = '0;
                        if (phase_q == PH_CLAIMING)
                        begin
                            phase_q = PH_CLAIMED;
                            r.notify_valid = 1'b1;
                            r.notify_address = held_addr_q;
                            r.notify_state = PH_CLAIMED;
                        end
                    end
                end
            end
            default: ;
        endcase
        // claim lost for good
        if (lost)
        begin
            phase_q = PH_CANNOT;
            held_addr_q = NULL_ADDR;
            timer_on_q = 1'b0;
            timer_left_q = '0;
            r.notify_valid = 1'b1;
            r.notify_address = NULL_ADDR;
            r.notify_state = PH_CANNOT;
        end
        r.send_data = r.send_valid ? settings_q.own_name : '0;
        r.addr_now = held_addr_q;
        r.claim_phase = phase_q;
        return r;
    endfunction

    // random event, most often a claim frame aimed at the held address
    function automatic claim_event_t make_event();
        claim_event_t ev;
        int           pick;
        ev.opcode = 2'($urandom);
        ev.frame_id = 29'($urandom);
        ev.frame_length = 4'($urandom);
        ev.frame_data = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 12)
            ev.opcode = OP_START;
        else if (pick < 16)
            ev.opcode = OP_STOP;
        else if (pick < 85 && pick >= 55)
            ev.opcode = OP_TICK;
        else if (pick < 93)
        begin
            ev.opcode = OP_FRAME;
            ev.frame_id[23:0] = {CLAIM_PGN, held_addr_q};
            ev.frame_length = 4'($urandom_range(15, 8));
            case ($urandom_range(5))
                0: ev.frame_data = settings_q.own_name;
                1: ev.frame_data = settings_q.own_name + 64'd1;
                2: ev.frame_data = settings_q.own_name - 64'd1;
                3: ev.frame_data = '0;
                4: ev.frame_data = '1;
                default: ;
            endcase
            // broken frames: one filter condition off
            if (pick >= 85)
            begin
                case ($urandom_range(2))
                    0: ev.frame_length = 4'($urandom_range(7));
                    1: ev.frame_id[23:8] = ev.frame_id[23:8] ^ 16'($urandom_range(65535, 1));
                    default: ev.frame_id[7:0] = ev.frame_id[7:0] ^ 8'($urandom_range(255, 1));
                endcase
            end
        end
        return ev;
    endfunction

    // one register write request, predictor copy updated on acceptance
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_OWN_NAME:     settings_q.own_name = value;
            REG_PREFERRED:    settings_q.start_addr = value[7:0];
            REG_PRIORITY:     settings_q.frame_priority = value[2:0];
            REG_ARBITRARY:    settings_q.may_search = value[0];
            REG_TIMEOUT:      settings_q.claim_timeout_ticks = value[15:0];
            REG_LOW_UNICAST:  settings_q.lowest_unicast = value[7:0];
            REG_HIGH_UNICAST: settings_q.highest_unicast = value[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // one event request with random gaps ahead of it; valid stays high afterwards
    task automatic drive_event(claim_event_t ev, bit typed, claim_result_t want);
        claim_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            evt_ch.valid <= 1'b0;
        end
        @(negedge clk);
        evt_ch.valid        <= 1'b1;
        evt_ch.opcode       <= ev.opcode;
        evt_ch.frame_id     <= ev.frame_id;
        evt_ch.frame_length <= ev.frame_length;
        evt_ch.frame_data   <= ev.frame_data;
        do @(posedge clk); while (!evt_ch.ready);
        predicted = predict_claim(ev);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // stop sending and let every expected result come out
    task automatic wait_drained();
        @(negedge clk);
        evt_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register settings for one random segment, extremes first
    task automatic apply_settings(int seg);
        logic [63:0] name;
        logic [7:0]  pref;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [2:0]  prio;
        logic        arb;
        logic [15:0] tmo;
        if (seg == 0)
        begin
            name = '0; pref = '0; prio = '0; arb = 1'b0; tmo = '0; lo = '0; hi = '0;
        end
        else if (seg == 1)
        begin
            name = '1; pref = '1; prio = '1; arb = 1'b1; tmo = '1; lo = '0; hi = '1;
        end
        else
        begin
            name = {$urandom, $urandom};
            pref = 8'($urandom);
            prio = 3'($urandom);
            arb = ($urandom_range(9) != 0);
            tmo = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
            case ($urandom_range(4))
                0: begin lo = 8'd0; hi = 8'd253; end
                1: begin lo = 8'($urandom); hi = 8'($urandom); end
                2: begin lo = 8'($urandom); hi = lo + 8'($urandom_range(3)); end
                3: begin lo = 8'($urandom); hi = lo; end
                default: begin lo = 8'($urandom_range(255, 200)); hi = 8'd255; end
            endcase
        end
        write_reg(REG_OWN_NAME, name);
        write_reg(REG_PREFERRED, {56'd0, pref});
        write_reg(REG_PRIORITY, {61'd0, prio});
        write_reg(REG_ARBITRARY, {63'd0, arb});
        write_reg(REG_TIMEOUT, {48'd0, tmo});
        write_reg(REG_LOW_UNICAST, {56'd0, lo});
        write_reg(REG_HIGH_UNICAST, {56'd0, hi});
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, {$urandom, $urandom});
    endtask

    task automatic add_write(logic [2:0] idx, logic [63:0] value);
        stim_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.index = idx;
        row.value = value;
        directed_rows.push_back(row);
    endtask

    task automatic add_item(logic [1:0] op, logic [28:0] id, logic [3:0] len, logic [63:0] data,
                            bit typed, claim_result_t want);
        stim_row_t row;
        row = '{default: '0};
        row.ev.opcode = op;
        row.ev.frame_id = id;
        row.ev.frame_length = len;
        row.ev.frame_data = data;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    // result checker and activity counter for the watchdog
    always @(posedge clk)
    begin
        claim_result_t want;
        if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result request, expected none, actual %0h", $time,
                         res_ch.addr_now);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("send_valid", 64'(want.send_valid), 64'(res_ch.send_valid));
                check_field("send_id", 64'(want.send_id), 64'(res_ch.send_id));
                check_field("send_data", want.send_data, res_ch.send_data);
                check_field("notify_valid", 64'(want.notify_valid), 64'(res_ch.notify_valid));
                check_field("notify_address", 64'(want.notify_address),
                            64'(res_ch.notify_address));
                check_field("notify_state", 64'(want.notify_state), 64'(res_ch.notify_state));
                check_field("addr_now", 64'(want.addr_now), 64'(res_ch.addr_now));
                check_field("claim_phase", 64'(want.claim_phase), 64'(res_ch.claim_phase));
            end
        end
    end

    // watchdog on cycles with no request moving
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    // result receiver with random stalls
    initial
    begin
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // main sequence
    initial
    begin
        claim_result_t idle_res;
        claim_result_t first_claim;
        claim_result_t cannot_res;
        bit            prev_write;
        evt_ch.valid = 1'b0;
        evt_ch.opcode = '0;
        evt_ch.frame_id = '0;
        evt_ch.frame_length = '0;
        evt_ch.frame_data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        rst_n = 1'b0;

        // predictor reset
        settings_q.own_name = RST_OWN_NAME;
        settings_q.start_addr = RST_PREFERRED;
        settings_q.frame_priority = RST_PRIORITY;
        settings_q.may_search = RST_ARBITRARY;
        settings_q.claim_timeout_ticks = RST_TIMEOUT;
        settings_q.lowest_unicast = RST_LOW_UNICAST;
        settings_q.highest_unicast = RST_HIGH_UNICAST;
        held_addr_q = NULL_ADDR;
        phase_q = PH_IDLE;
        timer_left_q = '0;
        timer_on_q = 1'b0;

        idle_res = mk_result(1'b0, '0, '0, 1'b0, NULL_ADDR, PH_IDLE, NULL_ADDR, PH_IDLE);
        first_claim = mk_result(1'b1, {RST_PRIORITY, 2'b00, CLAIM_PGN, RST_PREFERRED},
                                RST_OWN_NAME, 1'b0, NULL_ADDR, PH_IDLE, RST_PREFERRED,
                                PH_CLAIMING);
        cannot_res = mk_result(1'b0, '0, '0, 1'b1, NULL_ADDR, PH_CANNOT, NULL_ADDR, PH_CANNOT);

        // directed table, reset settings first
        add_item(OP_TICK, '0, '0, '0, 1, idle_res);
        add_item(OP_STOP, '1, '1, '1, 1, idle_res);
        add_item(OP_START, '0, '0, '0, 1, first_claim);
        add_item(OP_FRAME, {5'd0, CLAIM_PGN, RST_PREFERRED}, MIN_FRAME_LEN, RST_OWN_NAME,
                 1, cannot_res);
        // arbitrary node with a range of 250 to 255, so the next address wraps past 255
        add_write(REG_OWN_NAME, 64'h8000_0000_0000_0000);
        add_write(REG_PREFERRED, 64'd255);
        add_write(REG_PRIORITY, 64'd7);
        add_write(REG_ARBITRARY, 64'd1);
        add_write(REG_TIMEOUT, 64'd0);
        add_write(REG_LOW_UNICAST, 64'd250);
        add_write(REG_HIGH_UNICAST, 64'd255);
        add_write(REG_UNUSED, '1);
        add_item(OP_START, '0, '0, '0, 0, '0);
        add_item(OP_FRAME, {5'h1F, CLAIM_PGN, 8'd255}, 4'd15, '1, 0, '0);
        add_item(OP_START, '0, '0, '0, 0, '0);
        add_item(OP_STOP, '0, '0, '0, 0, '0);
        add_item(OP_START, '0, '0, '0, 0, '0);
        add_item(OP_FRAME, {5'd0, CLAIM_PGN, 8'd255}, MIN_FRAME_LEN, '0, 0, '0);
        add_item(OP_FRAME, {5'd0, CLAIM_PGN, 8'd250}, 4'd7, '0, 0, '0);
        add_item(OP_FRAME, {5'd0, 16'hEEFF, 8'd250}, MIN_FRAME_LEN, '0, 0, '0);
        add_item(OP_FRAME, {5'd0, CLAIM_PGN, 8'd251}, MIN_FRAME_LEN, '0, 0, '0);
        add_item(OP_TICK, '0, '0, '0, 0, '0);
        add_item(OP_TICK, '0, '0, '0, 0, '0);
        add_item(OP_STOP, '0, '0, '0, 0, '0);
        // range of one address that is the held one
        add_write(REG_LOW_UNICAST, 64'd5);
        add_write(REG_HIGH_UNICAST, 64'd5);
        add_write(REG_PREFERRED, 64'd5);
        add_write(REG_TIMEOUT, 64'd2);
        add_item(OP_START, '0, '0, '0, 0, '0);
        add_item(OP_FRAME, {5'd0, CLAIM_PGN, 8'd5}, MIN_FRAME_LEN, '0, 1, cannot_res);
        // empty range, countdown over two ticks
        add_write(REG_PREFERRED, 64'd9);
        add_write(REG_LOW_UNICAST, 64'd10);
        add_write(REG_HIGH_UNICAST, 64'd9);
        add_item(OP_START, '0, '0, '0, 0, '0);
        add_item(OP_TICK, '0, '0, '0, 0, '0);
        add_item(OP_TICK, '0, '0, '0, 0, '0);
        add_item(OP_STOP, '0, '0, '0, 0, '0);
        add_item(OP_START, '0, '0, '0, 0, '0);
        add_item(OP_FRAME, {5'd0, CLAIM_PGN, 8'd9}, MIN_FRAME_LEN, '0, 1, cannot_res);
        // loser that may not search
        add_write(REG_ARBITRARY, 64'd0);
        add_write(REG_OWN_NAME, '1);
        add_write(REG_TIMEOUT, 64'd65535);
        add_item(OP_START, '0, '0, '0, 0, '0);
        add_item(OP_FRAME, {5'd0, CLAIM_PGN, 8'd9}, MIN_FRAME_LEN, '0, 1, cannot_res);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // walk the directed table
        prev_write = 1'b0;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                if (!prev_write)
                    wait_drained();
                write_reg(directed_rows[i].index, directed_rows[i].value);
            end
            else
                drive_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
            prev_write = directed_rows[i].is_write;
        end

        // random segments under three idle profiles
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 26 : (p == 1) ? 52 : 0;
            recv_idle_pct = (p == 0) ? 52 : (p == 1) ? 26 : 0;
            for (int s = 0; s < 4; s++)
            begin
                wait_drained();
                apply_settings(p * 4 + s);
                for (int n = 0; n < SEGMENT_ITEMS; n++)
                begin
                    if ($urandom_range(199) == 0)
                        wait_drained();
                    drive_event(make_event(), 0, '0);
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== can_address_claim_fsm_core.f =====
rtl/core/acf_pkg.sv
rtl/core/acf_evt_if.sv
rtl/core/acf_res_if.sv
rtl/core/acf_cfg_if.sv
rtl/core/acf_front.sv
rtl/core/acf_queue.sv
rtl/core/acf_back.sv
rtl/core/can_address_claim_fsm_core.sv
verif/testbench.sv
